// ===== rtl/lru_recency_tracker_unit_defines.svh =====
// ---------------------------------------------------------------------------
// lru recency tracker assertion macros
// shared concurrent assertion forms for the recency tracker
// ---------------------------------------------------------------------------
`ifndef LRU_RECENCY_TRACKER_UNIT_DEFINES_SVH
`define LRU_RECENCY_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define LRT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define LRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lrt_pkg.sv =====
// ---------------------------------------------------------------------------
// lru recency tracker package
// operation and status codes and the per-cell control group
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrt_pkg;

    // operation carried in the input tuser
    typedef enum logic [1:0] {
        ACT_GET    = 2'd0,
        ACT_SET    = 2'd1,
        ACT_EVICT  = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    // status carried in the result tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // broadcast to every cell, already qualified by the input transaction
    typedef struct packed {
        logic touch;   // move the matching key to the front
        logic insert;  // push a new key in at the front
        logic remove;  // close the gap at the matching key
        logic evict;   // drop the oldest valid cell
    } cell_ctrl_t;

endpackage

// ===== rtl/lrt_cell.sv =====
// ---------------------------------------------------------------------------
// lru recency tracker cell
// one position of the recency row: key, valid bit, compare and neighbour shift
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrt_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lrt_pkg::cell_ctrl_t  ctrl,
    input  logic [KEY_BITS-1:0]  cmp_key,
    input  logic [KEY_BITS-1:0]  left_key,
    input  logic                 left_valid,
    input  logic [KEY_BITS-1:0]  right_key,
    input  logic                 right_valid,
    input  logic                 pre_in,
    input  logic                 suf_in,
    input  logic [KEY_BITS-1:0]  evk_in,
    output logic [KEY_BITS-1:0]  key_q,
    output logic                 valid_q,
    output logic                 pre_out,
    output logic                 suf_out,
    output logic [KEY_BITS-1:0]  evk_out
);
    import lrt_pkg::*;

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                valid_reg, valid_next;
    logic                match;
    logic                is_last;

    // local compare and the match chains in both directions
    assign match   = valid_reg && (key_reg == cmp_key);
    assign pre_out = pre_in | match;
    assign suf_out = suf_in | match;

    // oldest valid cell hands its key down the evict chain
    assign is_last = valid_reg && !right_valid;
    assign evk_out = evk_in | (is_last ? key_reg : '0);

    // next key and valid from the neighbours
    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if ((ctrl.touch && suf_out) || ctrl.insert) begin
            key_next   = left_key;
            valid_next = left_valid;
        end else if (ctrl.remove && pre_out) begin
            key_next   = right_key;
            valid_next = right_valid;
        end else if (ctrl.evict && is_last) begin
            valid_next = 1'b0;
        end
    end

    // valid bit under reset, key left as payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_q   = key_reg;
    assign valid_q = valid_reg;

endmodule

// ===== rtl/lru_recency_tracker_unit.sv =====
// ---------------------------------------------------------------------------
// lru recency tracker
// recency stack of keys, most recently used in cell 0, built as a cell row
// ---------------------------------------------------------------------------
//  channel | direction | tdata                                  | tuser
//  s_axis  | in        | key[31:0]                              | action[1:0]
//  m_axis  | out       | victim_key[31:0], entry_count[36:32]   | status[1:0]
//
//  one transaction per cycle; the result is registered and appears the cycle
//  after the input transaction is accepted
//  the cycle is set by the compare and shift across the cell row: every cell
//  compares in parallel and the match chains ripple once through the row
//  s_axis_tready drops only while a finished result is stalled by m_axis_tready
//  reset clears the valid bits, the count and the output stage at once; no
//  clearing pass over the keys is needed
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_recency_tracker_unit_defines.svh"

module lru_recency_tracker_unit #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key[31:0]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // victim_key[31:0], entry_count[36:32]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import lrt_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic                accept;
    action_t             action;
    logic [KEY_BITS+31:0] key_ext;
    logic [KEY_BITS-1:0] cmd_key;

    logic [KEY_BITS-1:0] key_w   [ENTRIES];
    logic [ENTRIES-1:0]  valid_w;
    logic [ENTRIES-1:0]  pre_w;
    logic [ENTRIES:0]    suf_w;
    logic [KEY_BITS-1:0] evk_w   [ENTRIES+1];

    logic                hit;
    logic                full;
    logic                empty;
    cell_ctrl_t          ctrl_raw;
    cell_ctrl_t          ctrl;
    status_t             status_c;
    logic [KEY_BITS-1:0] evict_c;
    logic [KEY_BITS+31:0] evict_ext;

    logic [CNT_W-1:0]    tracked_count_reg, tracked_count_next;
    logic [CNT_W+4:0]    count_ext;

    logic                out_valid_reg, out_valid_next;
    status_t             status_reg;
    logic [31:0]         evicted_reg;
    logic [4:0]          count_out_reg;

    // input transaction and key narrowed to the tracked width
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = action_t'(s_axis_tuser);
    assign key_ext       = {{KEY_BITS{1'b0}}, s_axis_tdata};
    assign cmd_key       = key_ext[KEY_BITS-1:0];

    // the cell row
    assign suf_w[ENTRIES] = 1'b0;
    assign evk_w[ENTRIES] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic [KEY_BITS-1:0] left_key, right_key;
        logic                left_valid, right_valid, pre_in;

        if (i == 0) begin : g_head
            assign left_key   = cmd_key;
            assign left_valid = 1'b1;
            assign pre_in     = 1'b0;
        end else begin : g_body
            assign left_key   = key_w[i-1];
            assign left_valid = valid_w[i-1];
            assign pre_in     = pre_w[i-1];
        end

        if (i == ENTRIES - 1) begin : g_tail
            assign right_key   = '0;
            assign right_valid = 1'b0;
        end else begin : g_mid
            assign right_key   = key_w[i+1];
            assign right_valid = valid_w[i+1];
        end

        lrt_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .cmp_key     (cmd_key),
            .left_key    (left_key),
            .left_valid  (left_valid),
            .right_key   (right_key),
            .right_valid (right_valid),
            .pre_in      (pre_in),
            .suf_in      (suf_w[i+1]),
            .evk_in      (evk_w[i+1]),
            .key_q       (key_w[i]),
            .valid_q     (valid_w[i]),
            .pre_out     (pre_w[i]),
            .suf_out     (suf_w[i]),
            .evk_out     (evk_w[i])
        );
    end

    assign hit   = pre_w[ENTRIES-1];
    assign full  = valid_w[ENTRIES-1];
    assign empty = !valid_w[0];

    // operation decode
    always_comb begin
        ctrl_raw           = '0;
        status_c           = ST_OK;
        evict_c            = '0;
        tracked_count_next = tracked_count_reg;
        case (action)
            ACT_GET: begin
                if (hit) begin
                    ctrl_raw.touch = 1'b1;
                end else begin
                    status_c = ST_MISS;
                end
            end
            ACT_SET: begin
                if (hit) begin
                    ctrl_raw.touch = 1'b1;
                end else if (full) begin
                    status_c = ST_FULL;
                end else begin
                    ctrl_raw.insert    = 1'b1;
                    tracked_count_next = tracked_count_reg + 1'b1;
                end
            end
            ACT_EVICT: begin
                if (empty) begin
                    status_c = ST_EMPTY;
                end else begin
                    ctrl_raw.evict     = 1'b1;
                    evict_c            = evk_w[0];
                    tracked_count_next = tracked_count_reg - 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (hit) begin
                    ctrl_raw.remove    = 1'b1;
                    tracked_count_next = tracked_count_reg - 1'b1;
                end else begin
                    status_c = ST_MISS;
                end
            end
            default: begin
                status_c = ST_OK;
            end
        endcase
    end

    assign ctrl      = accept ? ctrl_raw : '0;
    assign evict_ext = {32'd0, evict_c};
    assign count_ext = {5'd0, tracked_count_next};

    // output stage valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tracked_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                tracked_count_reg <= tracked_count_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= status_c;
            evicted_reg   <= evict_ext[31:0];
            count_out_reg <= count_ext[4:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, count_out_reg, evicted_reg};
    assign m_axis_tuser  = status_reg;

    // count agrees with the valid bits
    `LRT_ASSERT_NOW(a_count_valid, aclk, aresetn, 1'b1,
        $countones(valid_w) == tracked_count_reg, "count differs from valid cells")
    // valid cells form an unbroken run from the front
    `LRT_ASSERT_NOW(a_valid_run, aclk, aresetn, 1'b1,
        ((valid_w >> 1) & ~valid_w) == '0, "gap in the valid cells")
    // both match chains agree
    `LRT_ASSERT_NOW(a_chain_agree, aclk, aresetn, 1'b1,
        pre_w[ENTRIES-1] == suf_w[0], "match chains disagree")
    // a successful evict lowers the count by one
    `LRT_ASSERT_NEXT(a_evict_count, aclk, aresetn, accept && ctrl_raw.evict,
        tracked_count_reg == $past(tracked_count_reg) - 1'b1, "evict count step wrong")

endmodule

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// lru recency tracker testbench
// drives get, set, evict and remove transactions into the tracker, keeps its
// own copy of the recency order to work out each expected result, and checks
// every result transaction field by field under random stalls on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import lrt_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1600;
    localparam int BLOCK_ITEMS  = 100;
    localparam int CALM_TAIL    = 150;
    localparam int POOL_KEYS    = 24;

    typedef struct packed {
        action_t     action;
        logic [31:0] key;
    } access_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] victim_key;
        logic [4:0]  entry_count;
    } outcome_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    access_t     pending_accesses[$];
    outcome_t    expected_outcomes[$];
    logic [31:0] recency_order[$];   // index 0 is the most recently used key
    logic [31:0] key_pool[POOL_KEYS];

    logic access_taken = 1'b0;
    int   src_gap      = 0;
    int   sink_stall   = 0;
    int   failures     = 0;
    int   status_seen[4];

    lru_recency_tracker_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // key[31:0]
        .s_axis_tuser  (s_axis_tuser),    // action[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // victim_key[31:0], entry_count[36:32]
        .m_axis_tuser  (m_axis_tuser)     // status[1:0]
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // apply one access to the local recency order and return its outcome
    function automatic outcome_t apply_access(access_t acc);
        outcome_t res;
        int       pos;
        res = '{status: ST_OK, victim_key: '0, entry_count: '0};
        pos = -1;
        foreach (recency_order[i]) begin
            if (pos < 0 && recency_order[i] == acc.key) pos = i;
        end
        case (acc.action)
            ACT_GET: begin
                if (pos < 0) begin
                    res.status = ST_MISS;
                end else begin
                    recency_order.delete(pos);
                    recency_order.insert(0, acc.key);
                end
            end
            ACT_SET: begin
                if (pos >= 0) begin
                    recency_order.delete(pos);
                    recency_order.insert(0, acc.key);
                end else if (recency_order.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    recency_order.insert(0, acc.key);
                end
            end
            ACT_EVICT: begin
                if (recency_order.size() == 0) res.status = ST_EMPTY;
                else res.victim_key = recency_order.pop_back();
            end
            default: begin
                if (pos < 0) res.status = ST_MISS;
                else recency_order.delete(pos);
            end
        endcase
        res.entry_count = 5'(recency_order.size());
        return res;
    endfunction

    task automatic queue_access(action_t action, logic [31:0] key);
        pending_accesses.push_back('{action: action, key: key});
    endtask

    // input driver: holds a transaction until taken, idles in random bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || access_taken) begin
            if (src_gap > 0) begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_accesses.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (pending_accesses.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
                s_axis_tvalid <= 1'b0;
                src_gap       <= $urandom_range(0, 17);
            end else begin
                access_t nxt;
                nxt = pending_accesses.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.key;
                s_axis_tuser  <= nxt.action;
            end
        end
    end

    // result sink: back-pressure in random bursts
    always @(negedge aclk) begin
        if (sink_stall > 0) begin
            sink_stall    <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (pending_accesses.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            sink_stall    <= $urandom_range(0, 17);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: check result transactions, then predict for input transactions
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            access_taken <= 1'b0;
        end else begin
            access_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{status: status_t'(m_axis_tuser), victim_key: m_axis_tdata[31:0],
                        entry_count: m_axis_tdata[36:32]};
                if (expected_outcomes.size() == 0) begin
                    $error("result transaction with nothing expected");
                    failures++;
                end else begin
                    want = expected_outcomes.pop_front();
                    status_seen[want.status]++;
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        failures++;
                    end
                    if (got.victim_key !== want.victim_key) begin
                        $error("victim_key mismatch: expected %08h, actual %08h",
                               want.victim_key, got.victim_key);
                        failures++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.entry_count, got.entry_count);
                        failures++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_outcomes.push_back(apply_access('{action: action_t'(s_axis_tuser),
                                                           key: s_axis_tdata}));
            end
        end
    end

    // stimulus and end of run
    initial begin
        int          mode;
        int          roll;
        action_t     act;
        logic [31:0] key;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_KEYS; i++) key_pool[i] = $urandom;

        // directed: empty evict, misses, extreme keys, re-insert, fill to full
        queue_access(ACT_EVICT, $urandom);
        queue_access(ACT_GET, 32'h1234_5678);
        queue_access(ACT_REMOVE, 32'h1234_5678);
        queue_access(ACT_SET, 32'h0000_0000);
        queue_access(ACT_SET, 32'hFFFF_FFFF);
        queue_access(ACT_SET, 32'h0000_0000);
        queue_access(ACT_GET, 32'hFFFF_FFFF);
        queue_access(ACT_REMOVE, 32'h0000_0000);
        queue_access(ACT_EVICT, 32'h0000_0000);
        for (int i = 0; i < DEPTH; i++) queue_access(ACT_SET, key_pool[i]);
        queue_access(ACT_SET, key_pool[DEPTH]);

        // random blocks leaning towards filling, draining or neither
        for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
            mode = $urandom_range(0, 2);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       act = roll < 55 ? ACT_SET : roll < 80 ? ACT_GET :
                                   roll < 90 ? ACT_EVICT : ACT_REMOVE;
                    1:       act = roll < 15 ? ACT_SET : roll < 35 ? ACT_GET :
                                   roll < 70 ? ACT_EVICT : ACT_REMOVE;
                    default: act = roll < 30 ? ACT_SET : roll < 60 ? ACT_GET :
                                   roll < 80 ? ACT_EVICT : ACT_REMOVE;
                endcase
                if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
                else key = $urandom;
                queue_access(act, key);
            end
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (pending_accesses.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (expected_outcomes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d hits or completions, %0d untracked keys, %0d full rejections,",
                 status_seen[ST_OK], status_seen[ST_MISS], status_seen[ST_FULL]);
        $display("and %0d evicts on an empty tracker, with random stalls on both channels",
                 status_seen[ST_EMPTY]);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
